// ----- design/steq_pkg.sv -----
// Shared types and constants for the sorted timeout event queue.
// Used by steq_cell, steq_out_stage and sorted_timeout_event_queue_core.
`default_nettype none
package steq_pkg;

  localparam int unsigned DEPTH     = 16;
  localparam int unsigned BURST_MAX = 16;
  localparam int unsigned BURST_W   = $clog2(BURST_MAX);

  localparam int unsigned TIME_W = 32;
  localparam int unsigned DUR_W  = 24;
  localparam int unsigned TAG_W  = 8;
  localparam int unsigned KIND_W = 2;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_ADD  = 1'b1;

  localparam logic [KIND_W-1:0] KIND_ACCEPTED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REJECTED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EXPIRED  = 2'd2;

  typedef struct packed {
    logic [TIME_W-1:0] expiry;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  // Commands broadcast to every cell of the chain.
  typedef struct packed {
    logic   insert;
    logic   pop;
    entry_t new_entry;
  } cell_ctrl_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] time_now;
    logic              last;
  } result_t;

endpackage
`default_nettype wire

// ----- design/sorted_timeout_event_queue_core.sv -----
// Top level of the sorted timeout event queue: control, seconds counter, cell chain.
// Depends on steq_pkg, steq_cell and steq_out_stage.
//
//   Channel | Direction | Handshake               | Payload
//   --------+-----------+-------------------------+----------------------------------------
//   in      | sink      | in_valid_i / in_stall_o | operation_i, duration_i, event_tag_i
//   out     | source    | out_valid_o/out_stall_i | kind_o, expired_tag_o, time_now_o, last_o
//
// An add is inserted into the cell chain and its result is loaded into the output register
// on the transfer edge, so adds may follow each other every cycle while the output is free.
// A tick advances the counter on its transfer edge and then pops due entries one at a time
// (at most BURST_MAX), as the chain shifts by one cell per pop. A stalled output register
// holds the chain and blocks new input transfers.
// Reset empties the queue and clears the seconds counter; entry payloads are not reset.
`default_nettype none
module sorted_timeout_event_queue_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic                            operation_i,
  input  wire logic [steq_pkg::DUR_W-1:0]      duration_i,
  input  wire logic [steq_pkg::TAG_W-1:0]      event_tag_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic      [steq_pkg::KIND_W-1:0]     kind_o,
  output logic      [steq_pkg::TAG_W-1:0]      expired_tag_o,
  output logic      [steq_pkg::TIME_W-1:0]     time_now_o,
  output logic                                 last_o
);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_EXPIRE = 1'b1;

  localparam int unsigned D = steq_pkg::DEPTH;

  logic state_q, state_d;
  logic [steq_pkg::TIME_W-1:0]  sec_q, sec_d;
  logic [steq_pkg::BURST_W-1:0] burst_q, burst_d;

  logic                         out_free;
  logic                         out_load;
  steq_pkg::result_t            out_result;
  steq_pkg::result_t            out_q;

  steq_pkg::cell_ctrl_t         ctrl;
  logic                         cell_valid [D];
  logic                         cell_keep  [D];
  steq_pkg::entry_t             cell_entry [D];

  logic                         in_fire;
  logic                         is_add;
  logic                         full;
  logic [steq_pkg::TIME_W:0]    exp_sum;
  logic [steq_pkg::TIME_W-1:0]  new_expiry;
  logic                         head_due;
  logic                         next_due;
  logic                         burst_end;
  logic                         pop_last;

  // The input side is open only between items and while the output register can take a
  // result in the same cycle.
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign is_add     = (operation_i == steq_pkg::OP_ADD);
  assign full       = cell_valid[D-1];

  // Expiry is now plus duration, saturating at the counter's maximum.
  assign exp_sum    = {1'b0, sec_q} + {{(steq_pkg::TIME_W + 1 - steq_pkg::DUR_W){1'b0}},
                                       duration_i};
  assign new_expiry = exp_sum[steq_pkg::TIME_W] ? '1 : exp_sum[steq_pkg::TIME_W-1:0];

  // Due checks on the head and on the entry that becomes head after a pop.
  assign head_due  = cell_valid[0] && (cell_entry[0].expiry <= sec_q);
  assign next_due  = cell_valid[1] && (cell_entry[1].expiry <= sec_q);
  assign burst_end = (burst_q == steq_pkg::BURST_W'(steq_pkg::BURST_MAX - 1));
  assign pop_last  = !next_due || burst_end;

  always_comb begin
    state_d              = state_q;
    sec_d                = sec_q;
    burst_d              = burst_q;
    ctrl.insert          = 1'b0;
    ctrl.pop             = 1'b0;
    ctrl.new_entry.expiry = new_expiry;
    ctrl.new_entry.tag   = event_tag_i;
    out_load             = 1'b0;
    out_result.kind      = steq_pkg::KIND_ACCEPTED;
    out_result.tag       = event_tag_i;
    out_result.time_now  = sec_q;
    out_result.last      = 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (is_add) begin
            out_load        = 1'b1;
            ctrl.insert     = !full;
            out_result.kind = full ? steq_pkg::KIND_REJECTED : steq_pkg::KIND_ACCEPTED;
          end else begin
            if (sec_q != '1) begin
              sec_d = sec_q + 1'b1;
            end
            burst_d = '0;
            state_d = ST_EXPIRE;
          end
        end
      end
      ST_EXPIRE: begin
        out_result.kind = steq_pkg::KIND_EXPIRED;
        out_result.tag  = cell_entry[0].tag;
        out_result.last = pop_last;
        if (!head_due) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_load = 1'b1;
          ctrl.pop = 1'b1;
          burst_d  = burst_q + 1'b1;
          if (pop_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sec_q   <= '0;
      burst_q <= '0;
    end else begin
      state_q <= state_d;
      sec_q   <= sec_d;
      burst_q <= burst_d;
    end
  end

  // Cell chain: cell 0 is the head, which expires first.
  for (genvar i = 0; i < D; i++) begin : g_cell
    logic             left_valid;
    logic             left_keep;
    steq_pkg::entry_t left_entry;
    logic             right_valid;
    steq_pkg::entry_t right_entry;

    if (i == 0) begin : g_head
      assign left_valid = 1'b1;
      assign left_keep  = 1'b1;
      assign left_entry = ctrl.new_entry;
    end else begin : g_mid
      assign left_valid = cell_valid[i-1];
      assign left_keep  = cell_keep[i-1];
      assign left_entry = cell_entry[i-1];
    end

    if (i == D - 1) begin : g_tail
      assign right_valid = 1'b0;
      assign right_entry = cell_entry[i];
    end else begin : g_body
      assign right_valid = cell_valid[i+1];
      assign right_entry = cell_entry[i+1];
    end

    steq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .left_valid_i  (left_valid),
      .left_keep_i   (left_keep),
      .left_entry_i  (left_entry),
      .right_valid_i (right_valid),
      .right_entry_i (right_entry),
      .valid_o       (cell_valid[i]),
      .keep_o        (cell_keep[i]),
      .entry_o       (cell_entry[i])
    );
  end

  steq_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (out_load),
    .result_i    (out_result),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_q)
  );

  assign kind_o        = out_q.kind;
  assign expired_tag_o = out_q.tag;
  assign time_now_o    = out_q.time_now;
  assign last_o        = out_q.last;

  // Valid cells stay packed toward the head (checked on the two front cells).
  a_head_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_valid[1] |-> cell_valid[0])
    else $error("queue has a hole at the head");

  // The two front entries stay in expiry order.
  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_valid[1] |-> (cell_entry[0].expiry <= cell_entry[1].expiry))
    else $error("queue head out of order");

  // Every add transfer shows its result on the next cycle.
  a_add_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && is_add) |=> (out_valid_o && last_o &&
                             (kind_o == steq_pkg::KIND_ACCEPTED ||
                              kind_o == steq_pkg::KIND_REJECTED)))
    else $error("add transfer gave no result");

  // A pop always presents an expired result.
  a_pop_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.pop |=> (out_valid_o && kind_o == steq_pkg::KIND_EXPIRED))
    else $error("pop without expired result");

  // Inputs are refused while a tick is still draining.
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !is_add) |=> in_stall_o)
    else $error("input open during expiry burst");

endmodule
`default_nettype wire

// ----- design/steq_cell.sv -----
// One slot of the sorted queue chain: holds an entry and shifts with its neighbors.
// Depends on steq_pkg.
`default_nettype none
module steq_cell (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire steq_pkg::cell_ctrl_t ctrl_i,
  input  wire logic                left_valid_i,
  input  wire logic                left_keep_i,
  input  wire steq_pkg::entry_t    left_entry_i,
  input  wire logic                right_valid_i,
  input  wire steq_pkg::entry_t    right_entry_i,
  output logic                     valid_o,
  output logic                     keep_o,
  output steq_pkg::entry_t         entry_o
);

  logic             valid_q, valid_d;
  steq_pkg::entry_t entry_q, entry_d;

  // An entry stays put on insert when it expires no later than the new one.
  assign keep_o = valid_q && (entry_q.expiry <= ctrl_i.new_entry.expiry);

  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    if (ctrl_i.insert) begin
      valid_d = valid_q | left_valid_i;
      if (!keep_o) begin
        entry_d = left_keep_i ? ctrl_i.new_entry : left_entry_i;
      end
    end else if (ctrl_i.pop) begin
      valid_d = right_valid_i;
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign valid_o = valid_q;
  assign entry_o = entry_q;

endmodule
`default_nettype wire

// ----- design/steq_out_stage.sv -----
// Output register for result transfers, decoupling the queue from a stalling sink.
// Depends on steq_pkg.
`default_nettype none
module steq_out_stage (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               load_i,
  input  wire steq_pkg::result_t  result_i,
  output logic                    free_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output steq_pkg::result_t       result_o
);

  logic              valid_q, valid_d;
  steq_pkg::result_t result_q;

  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule
`default_nettype wire
